// ----- hw/rtl/mcmh_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcmh_pkg
// Shared constants for the motor command decoder and hold loop.
// ----------------------------------------------------------------------------
package mcmh_pkg;
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_VOLT = 2'd1;
  localparam logic [1:0] MODE_SPIN = 2'd2;
  localparam logic [1:0] MODE_HOLD = 2'd3;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_VOLT = 2'd1;
  localparam logic [1:0] ACT_SPIN = 2'd2;

  localparam logic [2:0] REG_DRIVE = 3'd0;
  localparam logic [2:0] REG_GAIN  = 3'd1;
  localparam logic [2:0] REG_ZERO  = 3'd2;
  localparam logic [2:0] REG_KP    = 3'd3;
  localparam logic [2:0] REG_KI    = 3'd4;
  localparam logic [2:0] REG_KD    = 3'd5;
  localparam logic [2:0] REG_LIMIT = 3'd6;
  localparam logic [2:0] REG_BAND  = 3'd7;

  localparam logic [10:0] ID_LOW  = 11'h100;
  localparam logic [10:0] ID_HIGH = 11'h200;
  localparam logic signed [15:0] MAGIC_SPIN = 16'sd4321;
  localparam logic signed [15:0] MAGIC_HOLD = 16'sd2345;
  localparam logic signed [15:0] MAX_CMD_MV = 16'sd12000;
  localparam logic signed [15:0] SPIN_VEL   = 16'sd31;
  localparam logic signed [15:0] APPR_VEL   = 16'sd90;
  localparam logic [13:0]        SPIN_MV    = 14'd6000;
  localparam logic signed [17:0] PI_Q12     = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
  localparam int unsigned        DT_MAX_US  = 500000;
  localparam int unsigned        DT_FALLBACK_US = 1000;
endpackage
`default_nettype wire

// ----- hw/rtl/mcmh_sermul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcmh_sermul
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-and-add.
// ----------------------------------------------------------------------------
module mcmh_sermul #(
  parameter int AW = 20,
  parameter int BW = 32
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  input  wire signed [AW-1:0]      a,
  input  wire signed [BW-1:0]      b,
  output logic                     done,
  output logic signed [AW+BW-1:0]  p
);
  localparam int CW = $clog2(BW + 1);
  logic signed [AW+BW-1:0] acc;
  logic signed [AW+BW-1:0] mcand;
  logic [BW-1:0]           mplier;
  logic [CW-1:0]           cnt;
  logic                    busy;

  // one partial product a cycle; the top bit of b carries negative weight
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= (AW+BW)'(a);
      mplier <= b;
    end else if (busy) begin
      if (mplier[0]) begin
        if (cnt == CW'(BW - 1)) acc <= acc - mcand;
        else acc <= acc + mcand;
      end
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
    end
  end

  assign p = acc;
endmodule
`default_nettype wire

// ----- hw/rtl/mcmh_serdiv.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mcmh_serdiv
// Restoring divider, one quotient bit per cycle, round half away from zero.
// ----------------------------------------------------------------------------
module mcmh_serdiv #(
  parameter int NW = 56,
  parameter int DW = 18
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire signed [NW-1:0] num,
  input  wire [DW-1:0]        den,
  output logic                done,
  output logic signed [NW-1:0] quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] q;
  logic [DW:0]   rem;
  logic [DW-1:0] d;
  logic          neg;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;

  assign trial = {rem[DW-1:0], q[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // magnitude plus half the divisor, then one bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[NW-1];
      q   <= (num[NW-1] ? -num : num) + NW'(den >> 1);
      rem <= '0;
      d   <= den;
    end else if (busy) begin
      if (trial >= {1'b0, d}) begin
        rem <= trial - {1'b0, d};
        q   <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[NW-2:0], 1'b0};
      end
    end
  end

  assign quo = neg ? -$signed(q) : $signed(q);
endmodule
`default_nettype wire

// ----- hw/rtl/motor_command_mode_and_hold_loop.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// motor_command_mode_and_hold_loop
// Frame command decoder, mode timeout and zero-hold PI-D loop for one drive.
// ----------------------------------------------------------------------------
// One beat in, one beat out, one beat worked at a time. Unmatched, spin and
// hold frames, idle, voltage and spin ticks, and hold ticks that time out, lie
// outside the band or have zero error go from the decode state to the output
// state. A voltage command frame runs one bit-serial product and one bit-serial
// division; any other hold tick runs four such products and two such divisions
// in sequence. The output register holds the result until taken; the next
// input beat can be taken the cycle after that.
module motor_command_mode_and_hold_loop #(
  parameter int TIME_WIDTH = 32,
  parameter int COMMAND_TIMEOUT_US = 100000
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         kind,
  input  wire  [31:0] now_us,
  input  wire  [10:0] frame_id,
  input  wire  [63:0] frame_data,
  input  wire  signed [15:0] shaft_angle,
  input  wire  signed [15:0] shaft_velocity,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [1:0]  control_mode_out,
  output logic        accepted,
  output logic [1:0]  drive_action,
  output logic signed [15:0] drive_voltage_mv,
  output logic signed [15:0] spin_velocity,
  output logic [13:0] spin_voltage_mv
);
  localparam int TW = TIME_WIDTH;
  localparam int MW = 56;

  // configuration registers
  logic [3:0]  r_drive;
  logic [15:0] r_gain, r_kp, r_ki, r_kd;
  logic [14:0] r_zero, r_limit;
  logic [13:0] r_band;
  logic [2:0]  reg_idx;
  assign reg_idx = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_drive <= 4'd1; r_gain <= 16'd4710; r_zero <= 15'd19907; r_kp <= 16'd3072;
      r_ki <= 16'd768; r_kd <= 16'd0; r_limit <= 15'd12000; r_band <= 14'd492;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        mcmh_pkg::REG_DRIVE: r_drive <= pwdata[3:0];
        mcmh_pkg::REG_GAIN:  r_gain  <= pwdata[15:0];
        mcmh_pkg::REG_ZERO:  r_zero  <= pwdata[14:0];
        mcmh_pkg::REG_KP:    r_kp    <= pwdata[15:0];
        mcmh_pkg::REG_KI:    r_ki    <= pwdata[15:0];
        mcmh_pkg::REG_KD:    r_kd    <= pwdata[15:0];
        mcmh_pkg::REG_LIMIT: r_limit <= pwdata[14:0];
        mcmh_pkg::REG_BAND:  r_band  <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mcmh_pkg::REG_DRIVE: prdata = {28'd0, r_drive};
      mcmh_pkg::REG_GAIN:  prdata = {16'd0, r_gain};
      mcmh_pkg::REG_ZERO:  prdata = {17'd0, r_zero};
      mcmh_pkg::REG_KP:    prdata = {16'd0, r_kp};
      mcmh_pkg::REG_KI:    prdata = {16'd0, r_ki};
      mcmh_pkg::REG_KD:    prdata = {16'd0, r_kd};
      mcmh_pkg::REG_LIMIT: prdata = {17'd0, r_limit};
      mcmh_pkg::REG_BAND:  prdata = {18'd0, r_band};
      default:             prdata = 32'd0;
    endcase
  end

  // state codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_VMUL  = 4'd2;
  localparam logic [3:0] S_VDIV  = 4'd3;
  localparam logic [3:0] S_IM1   = 4'd4;
  localparam logic [3:0] S_IM2   = 4'd5;
  localparam logic [3:0] S_IDIV  = 4'd6;
  localparam logic [3:0] S_PM1   = 4'd7;
  localparam logic [3:0] S_DM1   = 4'd9;
  localparam logic [3:0] S_ODIV  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;
  localparam logic [3:0] S_WAIT  = 4'd13;

  logic [3:0] state;

  // latched beat
  logic        i_kind;
  logic [TW-1:0] i_now;
  logic [10:0] i_id;
  logic [63:0] i_data;
  logic signed [15:0] i_ang, i_vel;

  // loop state
  logic [1:0]  mode;
  logic signed [15:0] vcmd, spin_rate;
  logic signed [39:0] integ;
  logic [TW-1:0] last_loop, last_cmd;

  // working values
  logic signed [17:0] err;
  logic [18:0]        dt;
  logic signed [MW-1:0] acc;

  // shared serial units
  logic              m_start, m_done;
  logic signed [23:0] m_a;
  logic signed [31:0] m_b;
  logic signed [55:0] m_p;
  logic              d_start, d_done;
  logic signed [MW-1:0] d_num;
  logic [17:0]       d_den;
  logic signed [MW-1:0] d_quo;

  mcmh_sermul #(.AW(24), .BW(32)) u_mul (
    .clk(clk), .rst(rst), .start(m_start), .a(m_a), .b(m_b),
    .done(m_done), .p(m_p));
  mcmh_serdiv #(.NW(MW), .DW(18)) u_div (
    .clk(clk), .rst(rst), .start(d_start), .num(d_num), .den(d_den),
    .done(d_done), .quo(d_quo));

  // frame decode
  logic        f_match;
  logic [1:0]  slot;
  logic signed [15:0] mv;
  always_comb begin
    f_match = 1'b0;
    slot = 2'd0;
    if (r_drive >= 4'd1 && r_drive <= 4'd4 && i_id == mcmh_pkg::ID_LOW) begin
      f_match = 1'b1; slot = 2'(r_drive - 4'd1);
    end else if (r_drive >= 4'd5 && r_drive <= 4'd8 && i_id == mcmh_pkg::ID_HIGH) begin
      f_match = 1'b1; slot = 2'(r_drive - 4'd5);
    end
    mv = $signed(i_data[16*slot +: 16]);
  end

  // tick timing
  logic [TW-1:0] since_cmd, since_loop;
  logic          timed_out;
  logic signed [17:0] err_raw, err_w;
  logic [17:0]   aerr;
  assign since_cmd  = i_now - last_cmd;
  assign since_loop = i_now - last_loop;
  assign timed_out  = 64'(since_cmd) > 64'(COMMAND_TIMEOUT_US);
  assign err_raw    = $signed({3'b000, r_zero}) - 18'(i_ang);
  // wrap to +-pi; out-of-range targets and angles can need up to three turns
  always_comb begin
    err_w = err_raw;
    for (int k = 0; k < 3; k++) begin
      if (err_w > mcmh_pkg::PI_Q12) err_w = err_w - mcmh_pkg::TWO_PI_Q12;
      else if (err_w < -mcmh_pkg::PI_Q12) err_w = err_w + mcmh_pkg::TWO_PI_Q12;
    end
  end
  assign aerr = err_w[17] ? 18'(-err_w) : 18'(err_w);

  // clamp helpers
  logic signed [MW-1:0] ilim, olim;
  assign ilim  = MW'({r_limit, 16'd0});
  assign olim  = MW'(r_limit);
  logic signed [MW-1:0] integ_sum;
  assign integ_sum = MW'(integ) + d_quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode <= mcmh_pkg::MODE_IDLE; vcmd <= '0; spin_rate <= '0; integ <= '0;
      last_loop <= '0; last_cmd <= '0;
      out_valid <= 1'b0; m_start <= 1'b0; d_start <= 1'b0;
    end else begin
      m_start <= 1'b0;
      d_start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            i_kind <= kind; i_now <= TW'(now_us); i_id <= frame_id;
            i_data <= frame_data; i_ang <= shaft_angle; i_vel <= shaft_velocity;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          control_mode_out <= mode; accepted <= 1'b0;
          drive_action <= mcmh_pkg::ACT_NONE; drive_voltage_mv <= '0;
          spin_velocity <= '0; spin_voltage_mv <= '0;
          state <= S_OUT;
          if (!i_kind) begin
            if (f_match) begin
              accepted <= 1'b1;
              last_cmd <= i_now;
              if (mv == mcmh_pkg::MAGIC_SPIN || mv == -mcmh_pkg::MAGIC_SPIN) begin
                spin_rate <= mv[15] ? -mcmh_pkg::SPIN_VEL : mcmh_pkg::SPIN_VEL;
                mode <= mcmh_pkg::MODE_SPIN;
              end else if (mv == mcmh_pkg::MAGIC_HOLD || mv == -mcmh_pkg::MAGIC_HOLD) begin
                if (mode != mcmh_pkg::MODE_HOLD) begin
                  integ <= '0; last_loop <= i_now; mode <= mcmh_pkg::MODE_HOLD;
                end
              end else begin
                m_a <= 24'(mv); m_b <= 32'($signed({1'b0, r_gain}));
                m_start <= 1'b1; state <= S_VMUL;
              end
            end
          end else begin
            case (mode)
              mcmh_pkg::MODE_VOLT: begin
                if (timed_out) begin
                  vcmd <= '0; mode <= mcmh_pkg::MODE_IDLE;
                end else begin
                  drive_action <= mcmh_pkg::ACT_VOLT; drive_voltage_mv <= vcmd;
                end
              end
              mcmh_pkg::MODE_SPIN: begin
                drive_action <= timed_out ? mcmh_pkg::ACT_VOLT : mcmh_pkg::ACT_SPIN;
                if (timed_out) mode <= mcmh_pkg::MODE_IDLE;
                else begin
                  spin_velocity <= spin_rate; spin_voltage_mv <= mcmh_pkg::SPIN_MV;
                end
              end
              mcmh_pkg::MODE_HOLD: begin
                if (timed_out) begin
                  integ <= '0; mode <= mcmh_pkg::MODE_IDLE;
                  drive_action <= mcmh_pkg::ACT_VOLT;
                end else begin
                  last_loop <= i_now;
                  err <= err_w;
                  if (since_loop == '0 ||
                      64'(since_loop) > 64'(mcmh_pkg::DT_MAX_US))
                    dt <= 19'(mcmh_pkg::DT_FALLBACK_US);
                  else dt <= 19'(since_loop);
                  if (aerr > {4'd0, r_band}) begin
                    integ <= '0;
                    spin_rate <= err_w[17] ? -mcmh_pkg::APPR_VEL : mcmh_pkg::APPR_VEL;
                    drive_action <= mcmh_pkg::ACT_SPIN;
                    spin_velocity <= err_w[17] ? -mcmh_pkg::APPR_VEL
                                               : mcmh_pkg::APPR_VEL;
                    spin_voltage_mv <= mcmh_pkg::SPIN_MV;
                  end else begin
                    spin_rate <= '0;
                    drive_action <= mcmh_pkg::ACT_VOLT;
                    if (err_w == '0) integ <= '0;
                    else begin
                      // ki*err first, then times dt
                      m_a <= 24'(err_w); m_b <= 32'($signed({1'b0, r_ki}));
                      m_start <= 1'b1; state <= S_IM1;
                    end
                  end
                end
              end
              default: ;
            endcase
          end
        end
        // voltage command: round(mv*gain/4096), clamp
        S_VMUL: if (m_done) begin
          d_num <= MW'(m_p); d_den <= 18'd4096; d_start <= 1'b1; state <= S_VDIV;
        end
        S_VDIV: if (d_done) begin
          if (d_quo > MW'(mcmh_pkg::MAX_CMD_MV)) vcmd <= mcmh_pkg::MAX_CMD_MV;
          else if (d_quo < -MW'(mcmh_pkg::MAX_CMD_MV)) vcmd <= -mcmh_pkg::MAX_CMD_MV;
          else vcmd <= d_quo[15:0];
          mode <= mcmh_pkg::MODE_VOLT;
          state <= S_OUT;
        end
        // ki*err needs up to 31 bits, so it goes in as the wide operand
        S_IM1: if (m_done) begin
          m_a <= 24'({5'd0, dt}); m_b <= m_p[31:0]; m_start <= 1'b1; state <= S_IM2;
        end
        S_IM2: if (m_done) begin
          d_num <= MW'(m_p); d_den <= 18'd16000; d_start <= 1'b1; state <= S_IDIV;
        end
        S_IDIV: if (d_done) begin
          if (integ_sum > ilim) integ <= 40'(ilim);
          else if (integ_sum < -ilim) integ <= 40'(-ilim);
          else integ <= 40'(integ_sum);
          m_a <= 24'(err); m_b <= 32'($signed({1'b0, r_kp}) * 125);
          m_start <= 1'b1; state <= S_PM1;
        end
        S_PM1: if (m_done) begin
          acc <= MW'(m_p) + (MW'(integ) <<< 1);
          m_a <= 24'(i_vel); m_b <= 32'($signed({1'b0, r_kd}) * 2000);
          m_start <= 1'b1; state <= S_DM1;
        end
        S_DM1: if (m_done) begin
          d_num <= acc - MW'(m_p); d_den <= 18'd131072; d_start <= 1'b1;
          state <= S_ODIV;
        end
        S_ODIV: if (d_done) begin
          if (d_quo > olim) drive_voltage_mv <= 16'(olim);
          else if (d_quo < -olim) drive_voltage_mv <= 16'(-olim);
          else drive_voltage_mv <= d_quo[15:0];
          state <= S_OUT;
        end
        S_OUT: begin
          control_mode_out <= mode;
          out_valid <= 1'b1;
          state <= S_WAIT;
        end
        S_WAIT: if (out_valid && out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
endmodule
`default_nettype wire
